// ----- rtl/sync_header_payload_deframer_assert.svh -----
// Assertion helpers for the deframer; clocked on clk, held off during reset.
`ifndef SYNC_HEADER_PAYLOAD_DEFRAMER_ASSERT_SVH
`define SYNC_HEADER_PAYLOAD_DEFRAMER_ASSERT_SVH

// Same-cycle implication
`define SHPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SHPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/shpd_pkg.sv -----
`default_nettype none

package shpd_pkg;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int ROLE_W      = 2;
    localparam int CFG_INDEX_W = 8;

    // Default frame layout
    localparam int HEADER_LEN_DEFAULT      = 8;
    localparam int LEN_BYTE_OFFSET_DEFAULT = 4;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET       = 8'd172;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_LEN_RESET = 8'd128;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_LEN = 8'd1;

    // Byte roles
    localparam logic [ROLE_W-1:0] ROLE_IGNORED = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_SYNC    = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_HEADER  = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd3;

    typedef struct packed {
        logic [ROLE_W-1:0] byte_role;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              frame_done;
        logic              frame_dropped;
        logic [BYTE_W-1:0] payload_length;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/shpd_core.sv -----
`default_nettype none

module shpd_core #(
    parameter int HEADER_LEN      = shpd_pkg::HEADER_LEN_DEFAULT,
    parameter int LEN_BYTE_OFFSET = shpd_pkg::LEN_BYTE_OFFSET_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [shpd_pkg::BYTE_W-1:0] data,
    input  wire logic [shpd_pkg::BYTE_W-1:0] sync_byte,
    input  wire logic [shpd_pkg::BYTE_W-1:0] max_payload_len,
    output shpd_pkg::result_t                result
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [shpd_pkg::BYTE_W-1:0] HDR_LAST_POS = shpd_pkg::BYTE_W'(HEADER_LEN);
    localparam logic [shpd_pkg::BYTE_W-1:0] LEN_POS      = shpd_pkg::BYTE_W'(LEN_BYTE_OFFSET);

    logic [1:0]                  phase_reg, phase_next;
    logic [shpd_pkg::BYTE_W-1:0] position_reg, position_next;
    logic [shpd_pkg::BYTE_W-1:0] length_reg, length_next;
    logic [shpd_pkg::BYTE_W-1:0] pos_inc;
    shpd_pkg::result_t           result_reg, result_next;

    assign pos_inc = position_reg + shpd_pkg::BYTE_W'(1);

    // Per-byte framing decision
    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        length_next   = length_reg;

        result_next.byte_role     = shpd_pkg::ROLE_IGNORED;
        result_next.byte_index    = '0;
        result_next.byte_value    = data;
        result_next.frame_done    = 1'b0;
        result_next.frame_dropped = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                result_next.byte_role  = shpd_pkg::ROLE_HEADER;
                result_next.byte_index = position_reg;
                if (position_reg == LEN_POS)
                begin
                    length_next = data;
                end
                position_next = pos_inc;
                if (pos_inc >= HDR_LAST_POS)
                begin
                    position_next = '0;
                    if (length_next > max_payload_len)
                    begin
                        result_next.frame_dropped = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else if (length_next == '0)
                    begin
                        result_next.frame_done = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                result_next.byte_role  = shpd_pkg::ROLE_PAYLOAD;
                result_next.byte_index = position_reg;
                position_next = pos_inc;
                if (pos_inc == length_reg)
                begin
                    result_next.frame_done = 1'b1;
                    phase_next    = PH_HUNT;
                    position_next = '0;
                end
            end
            default:
            begin
                // hunting, and the unused code behaves the same
                phase_next = PH_HUNT;
                if (data == sync_byte)
                begin
                    result_next.byte_role = shpd_pkg::ROLE_SYNC;
                    phase_next    = PH_HEADER;
                    position_next = '0;
                    length_next   = '0;
                end
            end
        endcase

        result_next.payload_length = length_next;
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            position_reg <= '0;
            length_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            length_reg   <= length_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/sync_header_payload_deframer.sv -----
// A byte's result passes the input register, then the result register, before
// it is offered; a stall on the result channel holds the byte in the input
// register. Throughput: one byte per cycle while the result channel does not
// stall; the per-byte decision is a few compares and one increment between the
// two registers.
// Reset (rst_n, asynchronous, active low): hunting for sync, counters clear,
// sync_byte = 172 and max_payload_len = 128, both stages empty.
`default_nettype none

`include "sync_header_payload_deframer_assert.svh"

module sync_header_payload_deframer #(
    parameter int HEADER_LEN      = shpd_pkg::HEADER_LEN_DEFAULT,
    parameter int LEN_BYTE_OFFSET = shpd_pkg::LEN_BYTE_OFFSET_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [shpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [shpd_pkg::BYTE_W-1:0]      cfg_data,
    // input byte channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [shpd_pkg::BYTE_W-1:0]      rx_byte,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [shpd_pkg::ROLE_W-1:0]           byte_role,
    output logic [shpd_pkg::BYTE_W-1:0]           byte_index,
    output logic [shpd_pkg::BYTE_W-1:0]           byte_value,
    output logic                                  frame_done,
    output logic                                  frame_dropped,
    output logic [shpd_pkg::BYTE_W-1:0]           payload_length
);

    logic [shpd_pkg::BYTE_W-1:0] sync_byte_reg;
    logic [shpd_pkg::BYTE_W-1:0] max_len_reg;
    logic                        in_valid_reg, in_valid_next;
    logic [shpd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        in_xfer;
    logic                        advance;
    shpd_pkg::result_t           result;

    // Configuration registers; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= shpd_pkg::SYNC_BYTE_RESET;
            max_len_reg   <= shpd_pkg::MAX_PAYLOAD_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                shpd_pkg::CFG_SYNC_BYTE:       sync_byte_reg <= cfg_data;
                shpd_pkg::CFG_MAX_PAYLOAD_LEN: max_len_reg   <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Two-stage handshake: input stage moves on when the result stage frees up
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input byte register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    shpd_core #(
        .HEADER_LEN      (HEADER_LEN),
        .LEN_BYTE_OFFSET (LEN_BYTE_OFFSET)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .data            (in_byte_reg),
        .sync_byte       (sync_byte_reg),
        .max_payload_len (max_len_reg),
        .result          (result)
    );

    assign out_valid      = out_valid_reg;
    assign byte_role      = result.byte_role;
    assign byte_index     = result.byte_index;
    assign byte_value     = result.byte_value;
    assign frame_done     = result.frame_done;
    assign frame_dropped  = result.frame_dropped;
    assign payload_length = result.payload_length;

    // Checks
    `SHPD_ASSERT_IMP(a_done_xor_drop, out_valid_reg, !(frame_done && frame_dropped),
        "frame both completed and dropped")
    `SHPD_ASSERT_IMP(a_payload_index, out_valid_reg && byte_role == shpd_pkg::ROLE_PAYLOAD,
        byte_index < payload_length, "payload index beyond captured length")
    `SHPD_ASSERT_IMP(a_drop_at_hdr_end, out_valid_reg && frame_dropped,
        byte_role == shpd_pkg::ROLE_HEADER
        && byte_index == shpd_pkg::BYTE_W'(HEADER_LEN - 1),
        "drop flagged away from the last header byte")
    `SHPD_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg,
        "input stage lost a byte while stalled")
    `SHPD_ASSERT_IMP(a_stall_only_full, in_stall, in_valid_reg,
        "input stalled with an empty input stage")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int HDR_LEN     = shpd_pkg::HEADER_LEN_DEFAULT;
    localparam int LEN_OFS     = shpd_pkg::LEN_BYTE_OFFSET_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_SLACK = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 192;

    // no register lives at this index; writes to it must be dropped
    localparam logic [shpd_pkg::CFG_INDEX_W-1:0] CFG_NO_SUCH_REG = 8'hFF;

    // shadow deframer phase codes
    localparam logic [1:0] HUNTING    = 2'd0;
    localparam logic [1:0] IN_HEADER  = 2'd1;
    localparam logic [1:0] IN_PAYLOAD = 2'd2;

    typedef enum logic [0:0] {ROW_BYTE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [7:0]        addr;
        logic [7:0]        data;
        bit                typed;
        shpd_pkg::result_t want;
    } stim_row_t;

    // DUT ports
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [shpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [shpd_pkg::BYTE_W-1:0]      cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [shpd_pkg::BYTE_W-1:0]      rx_byte = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [shpd_pkg::ROLE_W-1:0]      byte_role;
    logic [shpd_pkg::BYTE_W-1:0]      byte_index;
    logic [shpd_pkg::BYTE_W-1:0]      byte_value;
    logic                             frame_done;
    logic                             frame_dropped;
    logic [shpd_pkg::BYTE_W-1:0]      payload_length;

    // deframer shadow state and registers
    logic [1:0]     phase_q = HUNTING;
    logic [7:0]     pos_q = '0;
    logic [7:0]     len_q = '0;
    logic [7:0]     sync_cfg = shpd_pkg::SYNC_BYTE_RESET;
    logic [7:0]     max_cfg = shpd_pkg::MAX_PAYLOAD_LEN_RESET;

    shpd_pkg::result_t byte_reports_due[$];
    stim_row_t         directed[$];
    int unsigned       mismatches = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       quiet_cycles = 0;
    bit                in_up = 1'b0;
    bit                cfg_up = 1'b0;

    // per-phase register settings and idling mix
    logic [7:0]  sync_plan [PHASES] = '{8'd172, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'hC3, 8'd172};
    logic [7:0]  max_plan  [PHASES] = '{8'd128, 8'd0, 8'd255, 8'd16, 8'd255, 8'd3, 8'd1, 8'd200};
    int unsigned send_plan [4] = '{0, 64, 0, 32};
    int unsigned recv_plan [4] = '{0, 0, 64, 32};

    sync_header_payload_deframer #(
        .HEADER_LEN      (HDR_LEN),
        .LEN_BYTE_OFFSET (LEN_OFS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .byte_role      (byte_role),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .frame_done     (frame_done),
        .frame_dropped  (frame_dropped),
        .payload_length (payload_length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // role, index and flags of one received byte; advances the shadow state
    function automatic shpd_pkg::result_t classify_byte(input logic [7:0] b);
        shpd_pkg::result_t r;
        r = '0;
        r.byte_value = b;
        case (phase_q)
            IN_HEADER:
            begin
                r.byte_role  = shpd_pkg::ROLE_HEADER;
                r.byte_index = pos_q;
                if (pos_q == 8'(LEN_OFS))
                    len_q = b;
                pos_q = pos_q + 8'd1;
                if (pos_q >= 8'(HDR_LEN))
                begin
                    pos_q = '0;
                    if (len_q > max_cfg)
                    begin
                        r.frame_dropped = 1'b1;
                        phase_q = HUNTING;
                    end
                    else if (len_q == 8'd0)
                    begin
                        r.frame_done = 1'b1;
                        phase_q = HUNTING;
                    end
                    else
                        phase_q = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                r.byte_role  = shpd_pkg::ROLE_PAYLOAD;
                r.byte_index = pos_q;
                pos_q = pos_q + 8'd1;
                if (pos_q == len_q)
                begin
                    r.frame_done = 1'b1;
                    phase_q = HUNTING;
                    pos_q = '0;
                end
            end
            default:
            begin
                phase_q = HUNTING;
                if (b == sync_cfg)
                begin
                    r.byte_role = shpd_pkg::ROLE_SYNC;
                    phase_q = IN_HEADER;
                    pos_q = '0;
                    len_q = '0;
                end
            end
        endcase
        r.payload_length = len_q;
        return r;
    endfunction

    // declared payload length: mostly short and legal, some zero, some over the limit
    function automatic logic [7:0] draw_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        if (r < 25 && max_cfg != 8'hFF)
            return 8'($urandom_range(int'(max_cfg) + 1, 255));
        if (max_cfg == 8'd0)
            return 8'd0;
        if (r < 30)
            return 8'($urandom_range(1, int'(max_cfg)));
        return 8'($urandom_range(1, (max_cfg < 8'd24) ? int'(max_cfg) : 24));
    endfunction

    // next line byte: mostly well-formed frames, some noise while hunting
    function automatic logic [7:0] next_wire_byte();
        if (phase_q == HUNTING && $urandom_range(0, 99) < 75)
            return sync_cfg;
        if (phase_q == IN_HEADER && pos_q == 8'(LEN_OFS))
            return draw_length();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic plan_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input shpd_pkg::result_t want = '0);
        stim_row_t row;
        row.kind  = ROW_BYTE;
        row.addr  = '0;
        row.data  = b;
        row.typed = typed;
        row.want  = want;
        directed.push_back(row);
    endtask

    task automatic plan_write(input logic [7:0] idx, input logic [7:0] val);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.addr  = idx;
        row.data  = val;
        row.typed = 1'b0;
        row.want  = '0;
        directed.push_back(row);
    endtask

    // one byte transfer on the input channel, with a random gap in front
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input shpd_pkg::result_t want);
        shpd_pkg::result_t r;
        if (cfg_up)
        begin
            cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            if (in_up)
                in_valid <= 1'b0;
            in_up = 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        in_up = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = classify_byte(b);
        if (typed)
            r = want;
        byte_reports_due.push_back(r);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        if (in_up)
        begin
            in_valid <= 1'b0;
            in_up = 1'b0;
        end
        while (byte_reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_up = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == shpd_pkg::CFG_SYNC_BYTE)
            sync_cfg = val;
        else if (idx == shpd_pkg::CFG_MAX_PAYLOAD_LEN)
            max_cfg = val;
    endtask

    task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    task automatic check_result(input shpd_pkg::result_t got);
        shpd_pkg::result_t want;
        if (byte_reports_due.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            mismatches++;
            return;
        end
        want = byte_reports_due.pop_front();
        if (got.byte_role !== want.byte_role)
            flag_field("byte_role", 8'(want.byte_role), 8'(got.byte_role));
        if (got.byte_index !== want.byte_index)
            flag_field("byte_index", want.byte_index, got.byte_index);
        if (got.byte_value !== want.byte_value)
            flag_field("byte_value", want.byte_value, got.byte_value);
        if (got.frame_done !== want.frame_done)
            flag_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
        if (got.frame_dropped !== want.frame_dropped)
            flag_field("frame_dropped", 8'(want.frame_dropped), 8'(got.frame_dropped));
        if (got.payload_length !== want.payload_length)
            flag_field("payload_length", want.payload_length, got.payload_length);
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result('{byte_role, byte_index, byte_value, frame_done,
                           frame_dropped, payload_length});
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // watchdog: too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                   || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned counted;
        logic [7:0]  b;

        // good frame after reset: sync value and extremes inside the header, length 2
        plan_byte(8'h00, 1'b1, '{shpd_pkg::ROLE_IGNORED, 8'd0, 8'h00, 1'b0, 1'b0, 8'd0});
        plan_byte(8'd172, 1'b1, '{shpd_pkg::ROLE_SYNC, 8'd0, 8'd172, 1'b0, 1'b0, 8'd0});
        plan_byte(8'd172);
        plan_byte(8'hFF);
        plan_byte(8'h00);
        plan_byte(8'h55);
        plan_byte(8'd2);
        plan_byte(8'hAA);
        plan_byte(8'h01);
        plan_byte(8'h80);
        plan_byte(8'hAC);
        plan_byte(8'hFF, 1'b1, '{shpd_pkg::ROLE_PAYLOAD, 8'd1, 8'hFF, 1'b1, 1'b0, 8'd2});
        // limit lowered to zero in mid-header: length 1 is dropped
        plan_byte(8'd172);
        plan_byte(8'h12);
        plan_byte(8'h34);
        plan_byte(8'h56);
        plan_byte(8'h78);
        plan_write(shpd_pkg::CFG_MAX_PAYLOAD_LEN, 8'd0);
        plan_byte(8'd1);
        plan_byte(8'h9A);
        plan_byte(8'hBC);
        plan_byte(8'hDE, 1'b1, '{shpd_pkg::ROLE_HEADER, 8'd7, 8'hDE, 1'b0, 1'b1, 8'd1});
        // new sync value, write to a missing register, widest limit
        plan_write(shpd_pkg::CFG_SYNC_BYTE, 8'h00);
        plan_write(CFG_NO_SUCH_REG, 8'hFF);
        plan_write(shpd_pkg::CFG_MAX_PAYLOAD_LEN, 8'hFF);
        plan_byte(8'hFF, 1'b1, '{shpd_pkg::ROLE_IGNORED, 8'd0, 8'hFF, 1'b0, 1'b0, 8'd1});
        plan_byte(8'h00, 1'b1, '{shpd_pkg::ROLE_SYNC, 8'd0, 8'h00, 1'b0, 1'b0, 8'd0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(directed[i].addr, directed[i].data);
            end
            else
                send_byte(directed[i].data, directed[i].typed, directed[i].want);
        end

        // random frames, one register setting and idling mix per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_reg(shpd_pkg::CFG_SYNC_BYTE, sync_plan[ph]);
            write_reg(shpd_pkg::CFG_MAX_PAYLOAD_LEN, max_plan[ph]);
            send_idle_pct  = send_plan[ph % 4];
            recv_stall_pct = recv_plan[ph % 4];
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                b = next_wire_byte();
                if (phase_q != HUNTING || b == sync_cfg)
                    counted++;
                send_byte(b, 1'b0, '0);
            end
        end

        // wind down
        if (cfg_up)
        begin
            cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        drain_results();
        recv_stall_pct = 0;
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/shpd_pkg.sv
rtl/shpd_core.sv
rtl/sync_header_payload_deframer.sv
test/tb.sv
